// File: rtl/core/tmr4_pkg.sv
package tmr4_pkg;

	// Commands carried by one request.
	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	// Register byte offsets.
	localparam logic [6:0] ADDR_INTEN   = 7'h14;
	localparam logic [6:0] ADDR_INTST   = 7'h18;
	localparam logic [6:0] ADDR_CHEN    = 7'h1C;
	localparam logic [6:0] ADDR_CH_BASE = 7'h20;

	// Register offsets inside one channel block.
	localparam logic [3:0] REG_CTRL   = 4'h0;
	localparam logic [3:0] REG_RELOAD = 4'h4;
	localparam logic [3:0] REG_COUNT  = 4'h8;

	// Control field coding and word layout.
	localparam logic [2:0] MODE_32BIT   = 3'h1;
	localparam int         CH_BIT_STEP  = 4;
	localparam int         MAX_CHANNELS = 4;
	localparam int         WORD_W       = 16;
	localparam int         CTRL_W       = 5;

	// One request as held in the input stage.
	typedef struct packed {
		cmd_t        command;
		logic [6:0]  address;
		logic [31:0] write_data;
	} req_t;

	// One result as produced by the register core.
	typedef struct packed {
		logic [31:0] read_data;
		logic [3:0]  expired_mask;
		logic        irq_line;
	} rsp_t;

endpackage

// File: rtl/core/tmr4_core.sv
module tmr4_core
	import tmr4_pkg::*;
#(
	parameter int NUM_CHANNELS = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  req_t req,
	output rsp_t rsp
);

	logic [31:0]       count_q   [NUM_CHANNELS];
	logic [31:0]       reload_q  [NUM_CHANNELS];
	logic [CTRL_W-1:0] control_q [NUM_CHANNELS];
	logic [31:0]       count_d   [NUM_CHANNELS];
	logic [31:0]       reload_d  [NUM_CHANNELS];
	logic [CTRL_W-1:0] control_d [NUM_CHANNELS];
	logic [WORD_W-1:0] chen_q, chen_d;
	logic [WORD_W-1:0] inten_q, inten_d;
	logic [WORD_W-1:0] intst_q, intst_d;

	logic       is_tick, is_read, is_write;
	logic       ch_space;
	logic [6:0] ch_offset;
	logic [2:0] ch_sel;
	logic [3:0] reg_sel;
	logic [3:0] expired;
	logic [31:0] rdata;

	// Address decode shared by reads and writes.
	assign is_tick   = (req.command == CMD_TICK);
	assign is_read   = (req.command == CMD_READ);
	assign is_write  = (req.command == CMD_WRITE);
	assign ch_offset = req.address - ADDR_CH_BASE;
	assign ch_sel    = ch_offset[6:4];
	assign reg_sel   = ch_offset[3:0];
	assign ch_space  = (req.address >= ADDR_CH_BASE) && (req.address[1:0] == 2'b00);

	// Next-state logic for the global words and each channel.
	always_comb begin
		chen_d  = chen_q;
		inten_d = inten_q;
		intst_d = intst_q;
		expired = '0;
		if (is_write && req.address == ADDR_INTEN) begin
			inten_d = req.write_data[WORD_W-1:0];
		end
		if (is_write && req.address == ADDR_INTST) begin
			intst_d = intst_q & ~req.write_data[WORD_W-1:0];
		end
		if (is_write && req.address == ADDR_CHEN) begin
			chen_d = req.write_data[WORD_W-1:0];
		end
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			count_d[c]   = count_q[c];
			reload_d[c]  = reload_q[c];
			control_d[c] = control_q[c];
			if (is_tick && chen_q[c*CH_BIT_STEP] && control_q[c][2:0] == MODE_32BIT) begin
				if (count_q[c] == 32'd0) begin
					count_d[c] = reload_q[c];
					expired[c] = 1'b1;
					intst_d[c*CH_BIT_STEP] = 1'b1;
				end else begin
					count_d[c] = count_q[c] - 32'd1;
				end
			end
			// A rising channel enable loads the counter from its reload value.
			if (is_write && req.address == ADDR_CHEN &&
			    req.write_data[c*CH_BIT_STEP] && !chen_q[c*CH_BIT_STEP]) begin
				count_d[c] = reload_q[c];
			end
			if (is_write && ch_space && ch_sel == 3'(c)) begin
				if (reg_sel == REG_CTRL) begin
					control_d[c] = req.write_data[CTRL_W-1:0];
				end
				if (reg_sel == REG_RELOAD) begin
					reload_d[c] = req.write_data;
				end
			end
		end
	end

	// Read data selection.
	always_comb begin
		rdata = '0;
		if (is_read) begin
			case (req.address)
				ADDR_INTEN: rdata = {16'd0, inten_q};
				ADDR_INTST: rdata = {16'd0, intst_q};
				ADDR_CHEN:  rdata = {16'd0, chen_q};
				default: begin
					for (int c = 0; c < NUM_CHANNELS; c++) begin
						if (ch_space && ch_sel == 3'(c)) begin
							if (reg_sel == REG_CTRL) begin
								rdata = {27'd0, control_q[c]};
							end
							if (reg_sel == REG_RELOAD) begin
								rdata = reload_q[c];
							end
							if (reg_sel == REG_COUNT) begin
								rdata = count_q[c];
							end
						end
					end
				end
			endcase
		end
	end

	assign rsp.read_data    = rdata;
	assign rsp.expired_mask = expired;
	assign rsp.irq_line     = |(intst_d & inten_d);

	// State registers, updated once per request taken from the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chen_q  <= '0;
			inten_q <= '0;
			intst_q <= '0;
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				count_q[c]   <= '0;
				reload_q[c]  <= '0;
				control_q[c] <= '0;
			end
		end else if (step) begin
			chen_q  <= chen_d;
			inten_q <= inten_d;
			intst_q <= intst_d;
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				count_q[c]   <= count_d[c];
				reload_q[c]  <= reload_d[c];
				control_q[c] <= control_d[c];
			end
		end
	end

endmodule

// File: rtl/core/interval_timer_4ch_regs_unit.sv
// Four-channel 32-bit down-counting interval timer behind a request/response
// register port. Each request is a timer tick, a register read or a register
// write, and each produces exactly one response with read data, the mask of
// channels that expired and reloaded on that tick, and the interrupt line
// after the request's update. Requests pass through an input register and
// the register core into an output register, and one request is taken every
// cycle while the output register is free or drained.
module interval_timer_4ch_regs_unit
	import tmr4_pkg::*;
#(
	parameter int NUM_CHANNELS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [6:0]  address,
	input  logic [31:0] write_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] read_data,
	output logic [3:0]  expired_mask,
	output logic        irq_line
);

	logic valid_s1;
	req_t req_s1;
	rsp_t rsp;
	logic advance;
	logic out_valid_q;
	rsp_t rsp_q;

	// The input stage moves on when the output register can take a result.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1.command    <= cmd_t'(command);
			req_s1.address    <= address;
			req_s1.write_data <= write_data;
		end
	end

	tmr4_core #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.req    (req_s1),
		.rsp    (rsp)
	);

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp;
		end
	end

	assign out_valid    = out_valid_q;
	assign read_data    = rsp_q.read_data;
	assign expired_mask = rsp_q.expired_mask;
	assign irq_line     = rsp_q.irq_line;

endmodule

// File: rtl/core/tmr4_checker.sv
module tmr4_checker #(
	parameter int NUM_CHANNELS = 4
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  command,
	input logic [6:0]  address,
	input logic [31:0] write_data,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] read_data,
	input logic [3:0]  expired_mask,
	input logic        irq_line
);

	// A stalled response holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data) &&
		$stable(expired_mask) && $stable(irq_line))
		else $error("response changed while stalled");

	// Only ticks expire channels and only reads return data.
	a_read_no_expire: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_data != 32'd0 |-> expired_mask == 4'd0)
		else $error("response carries both read data and expirations");

	// Channels beyond the configured count never expire.
	a_mask_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (expired_mask >> NUM_CHANNELS) == 4'd0)
		else $error("expiration reported for a missing channel");

	// With the output register empty, a request is always taken in the same cycle.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("request refused with the output empty");

endmodule

bind interval_timer_4ch_regs_unit tmr4_checker #(
	.NUM_CHANNELS(NUM_CHANNELS)
) u_tmr4_checker (.*);
